// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl of the list table unit
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check sampled on the rising edge, suspended while reset is asserted
`define ULT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check sampled on the rising edge, also live during reset
`define ULT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ULT_ASSERT(lbl, clk, rstn, prop, msg)
`define ULT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/ult_pkg.sv =====
// package for the unsorted list table unit: sizes, request, status and read select codes,
// and the command and status bundles between controller and datapath
// no dependencies
`default_nettype none

package ult_pkg;

    // list capacity and item size
    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = 5;
    localparam int REQ_W      = 3;
    localparam int ST_W       = 2;
    localparam int RD_W       = 3;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RETRIEVE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MAKE_EMPTY = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET_WALK = 3'd4;
    localparam logic [REQ_W-1:0] REQ_GET_NEXT   = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_PAST_END  = 2'd3;

    // read address selection for the entry memory
    localparam logic [RD_W-1:0] RD_NONE       = 3'd0;
    localparam logic [RD_W-1:0] RD_HEAD       = 3'd1;
    localparam logic [RD_W-1:0] RD_WALK       = 3'd2;
    localparam logic [RD_W-1:0] RD_SCAN_NEXT  = 3'd3;
    localparam logic [RD_W-1:0] RD_SHIFT_SRC  = 3'd4;
    localparam logic [RD_W-1:0] RD_SHIFT_NEXT = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic            cap;
        logic [RD_W-1:0] rd_sel;
        logic            scan_init;
        logic            scan_adv;
        logic            shift_init;
        logic            shift_adv;
        logic            ins_wr;
        logic            del_done;
        logic            clr;
        logic            walk_clr;
        logic            walk_inc;
        logic            res_ld;
        logic [ST_W-1:0] res_status;
        logic            res_found;
        logic            res_item_ld;
        logic            out_ld;
    } ult_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             walk_ok;
        logic             count_zero;
        logic             hit;
        logic             scan_last;
        logic             at_top;
        logic             shift_last;
        logic             out_busy;
    } ult_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ult_dp.sv =====
// datapath of the unsorted list table unit: entry memory, count, walk
// pointer, scan and shift pointers, result and output registers
// depends on ult_pkg
`default_nettype none

module ult_dp
    import ult_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [ITEM_WIDTH-1:0] item_in,
    input  wire ult_cmd_t              cmd,
    output ult_sts_t                   sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [ST_W-1:0]            status,
    output logic                       found,
    output logic [ITEM_WIDTH-1:0]      item_out,
    output logic [CNT_W-1:0]           item_count,
    output logic                       is_full
);

    // entries are kept oldest at address 0, the head at address count-1
    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rdata_reg;

    logic [REQ_W-1:0]      req_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      walk_reg;
    logic [IDX_W-1:0]      cmp_ptr_reg;
    logic [IDX_W-1:0]      sh_ptr_reg;

    logic [ST_W-1:0]       res_status_reg;
    logic                  res_found_reg;
    logic [ITEM_WIDTH-1:0] res_item_reg;

    logic                  out_valid_reg;
    logic [ST_W-1:0]       out_status_reg;
    logic                  out_found_reg;
    logic [ITEM_WIDTH-1:0] out_item_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_full_reg;

    logic [CNT_W-1:0]      top_cnt;
    logic [CNT_W-1:0]      walk_phys;
    logic [CNT_W-1:0]      sh_nx_cnt;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  wr_en;

    // address arithmetic
    assign top_cnt   = count_reg - CNT_W'(1);
    assign walk_phys = count_reg - walk_reg - CNT_W'(1);
    assign sh_nx_cnt = CNT_W'(sh_ptr_reg) + CNT_W'(2);

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HEAD:       rd_addr = top_cnt[IDX_W-1:0];
            RD_WALK:       rd_addr = walk_phys[IDX_W-1:0];
            RD_SCAN_NEXT:  rd_addr = cmp_ptr_reg - IDX_W'(1);
            RD_SHIFT_SRC:  rd_addr = cmp_ptr_reg + IDX_W'(1);
            RD_SHIFT_NEXT: rd_addr = sh_nx_cnt[IDX_W-1:0];
            default:       rd_addr = '0;
        endcase
    end

    // single write port: append on insert, move down during delete
    assign wr_en   = cmd.ins_wr | cmd.shift_adv;
    assign wr_addr = cmd.ins_wr ? count_reg[IDX_W-1:0] : sh_ptr_reg;
    assign wr_data = cmd.ins_wr ? item_reg : rdata_reg;

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // request capture and scan / shift pointers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            req_reg  <= req_type;
            item_reg <= item_in;
        end
        if (cmd.scan_init)
        begin
            cmp_ptr_reg <= top_cnt[IDX_W-1:0];
        end
        else if (cmd.scan_adv)
        begin
            cmp_ptr_reg <= cmp_ptr_reg - IDX_W'(1);
        end
        if (cmd.shift_init)
        begin
            sh_ptr_reg <= cmp_ptr_reg;
        end
        else if (cmd.shift_adv)
        begin
            sh_ptr_reg <= sh_ptr_reg + IDX_W'(1);
        end
    end

    // item count and walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.ins_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.del_done)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.walk_clr)
            begin
                walk_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                walk_reg <= walk_reg + CNT_W'(1);
            end
        end
    end

    // pending result of the request in flight
    always_ff @(posedge clk)
    begin
        if (cmd.res_ld)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found;
            res_item_reg   <= cmd.res_item_ld ? rdata_reg : '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_item_reg   <= res_item_reg;
            out_count_reg  <= count_reg;
            out_full_reg   <= (count_reg == DEPTH_CNT);
        end
    end

    // status towards the controller
    always_comb
    begin
        sts.req        = req_reg;
        sts.full       = (count_reg == DEPTH_CNT);
        sts.walk_ok    = (walk_reg < count_reg);
        sts.count_zero = (count_reg == '0);
        sts.hit        = (rdata_reg == item_reg);
        sts.scan_last  = (cmp_ptr_reg == '0);
        sts.at_top     = (cmp_ptr_reg == top_cnt[IDX_W-1:0]);
        sts.shift_last = (sh_nx_cnt == count_reg);
        sts.out_busy   = out_valid_reg & ~out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found      = out_found_reg;
    assign item_out   = out_item_reg;
    assign item_count = out_count_reg;
    assign is_full    = out_full_reg;

endmodule

`default_nettype wire

// ===== hdl/ult_ctrl.sv =====
// controller of the unsorted list table unit: sequences insert, scan,
// delete shift, walk and result hand-off through the datapath
// depends on ult_pkg
`default_nettype none

module ult_ctrl
    import ult_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ult_sts_t sts,
    output ult_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                cmd.res_ld = 1'b1;
                unique case (sts.req) inside
                    REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.ins_wr   = 1'b1;
                            cmd.walk_clr = 1'b1;
                        end
                    end
                    REQ_DELETE, REQ_RETRIEVE:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.res_status = (sts.req == REQ_DELETE) ? ST_NOT_FOUND : ST_OK;
                        end
                        else
                        begin
                            cmd.res_ld    = 1'b0;
                            cmd.scan_init = 1'b1;
                            cmd.rd_sel    = RD_HEAD;
                            state_next    = S_SCAN;
                        end
                    end
                    REQ_MAKE_EMPTY:
                    begin
                        cmd.clr      = 1'b1;
                        cmd.walk_clr = 1'b1;
                    end
                    REQ_RESET_WALK:
                    begin
                        cmd.walk_clr = 1'b1;
                    end
                    REQ_GET_NEXT:
                    begin
                        if (sts.walk_ok)
                        begin
                            cmd.res_ld = 1'b0;
                            cmd.rd_sel = RD_WALK;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.res_status = ST_PAST_END;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.res_ld      = 1'b1;
                cmd.res_item_ld = 1'b1;
                cmd.walk_inc    = 1'b1;
                state_next      = S_DONE;
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.req == REQ_DELETE)
                    begin
                        if (sts.at_top)
                        begin
                            // match at the head: nothing newer to move down
                            cmd.del_done = 1'b1;
                            cmd.walk_clr = 1'b1;
                            cmd.res_ld   = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            cmd.rd_sel     = RD_SHIFT_SRC;
                            state_next     = S_SHIFT;
                        end
                    end
                    else
                    begin
                        cmd.res_ld    = 1'b1;
                        cmd.res_found = 1'b1;
                        state_next    = S_DONE;
                    end
                end
                else if (sts.scan_last)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = (sts.req == REQ_DELETE) ? ST_NOT_FOUND : ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    cmd.rd_sel   = RD_SCAN_NEXT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_adv = 1'b1;
                cmd.rd_sel    = RD_SHIFT_NEXT;
                if (sts.shift_last)
                begin
                    cmd.del_done = 1'b1;
                    cmd.walk_clr = 1'b1;
                    cmd.res_ld   = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/unsorted_list_table_unit.sv =====
// top level of the unsorted list table unit: controller plus datapath
// depends on ult_pkg, ult_ctrl, ult_dp and assert_macros.svh
//
//  channel   direction  handshake            payload
//  request   in         in_valid / in_ready  req_type, item_in
//  result    out        out_valid/out_ready  status, found, item_out, item_count, is_full
//
// one request at a time; insert, make-empty, reset-walk: execute, then done
// get-next: execute, read, done, or execute, done past the end; retrieve and delete scan
// up to count entries from the head through the single read port of the entry memory, one entry per cycle
// for the scan and one entry per cycle for the move down after a delete
// a stalled result sits in the output register; the next request is taken
// meanwhile and its result waits until the register frees; reset empties list
`default_nettype none

`include "assert_macros.svh"

module unsorted_list_table_unit
    import ult_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [ITEM_WIDTH-1:0] item_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [ST_W-1:0]            status,
    output logic                       found,
    output logic [ITEM_WIDTH-1:0]      item_out,
    output logic [CNT_W-1:0]           item_count,
    output logic                       is_full
);

    ult_cmd_t cmd;
    ult_sts_t sts;

    // sequencing
    ult_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and result path
    ult_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .item_in    (item_in),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found      (found),
        .item_out   (item_out),
        .item_count (item_count),
        .is_full    (is_full)
    );

    // checks
    `ULT_ASSERT(a_count_range, clk, rst_n, out_valid |-> (item_count <= DEPTH_CNT), "item count above capacity")
    `ULT_ASSERT(a_full_flag, clk, rst_n, out_valid |-> (is_full == (item_count == DEPTH_CNT)), "full flag disagrees with count")
    `ULT_ASSERT(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "request taken while one is in flight")
    `ULT_ASSERT(a_item_zero, clk, rst_n, (out_valid && (status != ST_OK)) |-> (item_out == '0), "item returned with a failing status")
    `ULT_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result valid during reset")

endmodule

`default_nettype wire

// ===== dv/list_table_checker.sv =====
// checker for the unsorted list table unit: watches both channels, predicts each result
// from its own copy of the list and compares every field; depends on ult_pkg
`default_nettype none

module list_table_checker
    import ult_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [ITEM_WIDTH-1:0] item_in,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [ST_W-1:0]       status,
    input  wire logic                  found,
    input  wire logic [ITEM_WIDTH-1:0] item_out,
    input  wire logic [CNT_W-1:0]      item_count,
    input  wire logic                  is_full,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [ST_W-1:0]       status;
        logic                  found;
        logic [ITEM_WIDTH-1:0] item_out;
        logic [CNT_W-1:0]      item_count;
        logic                  is_full;
    } list_result_t;

    // shadow copy of the list, head at index 0
    logic [ITEM_WIDTH-1:0] slots [DEPTH];
    int                    held;
    int                    walk;

    list_result_t expected_results [$];
    int           errors;

    initial
    begin
        errors     = 0;
        held       = 0;
        walk       = 0;
    end

    // apply one request to the shadow list and work out its result
    task automatic apply_request(input logic [REQ_W-1:0] op,
                                 input logic [ITEM_WIDTH-1:0] item,
                                 output list_result_t res);
        int hit;
        res        = '0;
        res.status = ST_OK;
        hit        = -1;
        for (int i = 0; i < held; i++)
        begin
            if (hit < 0 && slots[i] == item)
                hit = i;
        end
        case (op)
            REQ_INSERT:
            begin
                if (held >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = held; i > 0; i--)
                        slots[i] = slots[i-1];
                    slots[0] = item;
                    held++;
                    walk = 0;
                end
            end
            REQ_DELETE:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = hit; i + 1 < held; i++)
                        slots[i] = slots[i+1];
                    held--;
                    walk = 0;
                end
            end
            REQ_RETRIEVE:
                res.found = (hit >= 0);
            REQ_MAKE_EMPTY:
            begin
                held = 0;
                walk = 0;
            end
            REQ_RESET_WALK:
                walk = 0;
            REQ_GET_NEXT:
            begin
                if (walk < held)
                begin
                    res.item_out = slots[walk];
                    walk++;
                end
                else
                    res.status = ST_PAST_END;
            end
            default: ;
        endcase
        res.item_count = CNT_W'(held);
        res.is_full    = (held == DEPTH);
    endtask

    // requests in, results out, compared against the oldest prediction
    always @(posedge clk)
    begin
        list_result_t predicted;
        list_result_t got;
        list_result_t want;
        if (!rst_n)
        begin
            held = 0;
            walk = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_request(req_type, item_in, predicted);
                expected_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                got = '{status, found, item_out, item_count, is_full};
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        errors++;
                    end
                    if (got.item_out !== want.item_out)
                    begin
                        $error("item_out: expected %h, actual %h", want.item_out, got.item_out);
                        errors++;
                    end
                    if (got.item_count !== want.item_count)
                    begin
                        $error("item_count: expected %0d, actual %0d",
                               want.item_count, got.item_count);
                        errors++;
                    end
                    if (got.is_full !== want.is_full)
                    begin
                        $error("is_full: expected %0d, actual %0d", want.is_full, got.is_full);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_results.size();
    end

endmodule

`default_nettype wire

// ===== dv/unsorted_list_table_unit_tb.sv =====
// testbench top for the unsorted list table unit: drives directed then phased random
// requests with random stalls on both sides; depends on ult_pkg and list_table_checker
`default_nettype none

module unsorted_list_table_unit_tb;
    import ult_pkg::*;

    localparam int ITEMS       = 1800;
    localparam int PHASE_LEN   = 60;
    localparam int CYCLE_LIMIT = 600000;

    // unused request codes
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    // random phase flavours
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_WALK  = 2;
    localparam int MODE_MIXED = 3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type  = '0;
    logic [ITEM_WIDTH-1:0] item_in   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ST_W-1:0]       status;
    logic                  found;
    logic [ITEM_WIDTH-1:0] item_out;
    logic [CNT_W-1:0]      item_count;
    logic                  is_full;

    int fail_count;
    int pending;
    int cycle_count;
    bit req_rush;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    unsorted_list_table_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .item_in    (item_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found      (found),
        .item_out   (item_out),
        .item_count (item_count),
        .is_full    (is_full)
    );

    list_table_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .item_in    (item_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found      (found),
        .item_out   (item_out),
        .item_count (item_count),
        .is_full    (is_full),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // one request: optional idle gap, then hold valid until taken
    task automatic send_req(input logic [REQ_W-1:0] op, input logic [ITEM_WIDTH-1:0] item);
        int gap;
        gap = req_rush ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        item_in  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // result side back-pressure, with stretches of no stalling
    initial
    begin
        int  stall;
        int  taken;
        bit  rsp_rush;
        taken    = 0;
        rsp_rush = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 20 == 0)
                rsp_rush = ($urandom_range(0, 3) == 0);
            stall = rsp_rush ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [ITEM_WIDTH-1:0] pool [8];
        logic [ITEM_WIDTH-1:0] item;
        logic [REQ_W-1:0]      op;
        int                    mode;
        int                    roll;
        req_rush = 1'b0;
        mode     = MODE_MIXED;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corners, extreme items, walk past the end, spare codes
        send_req(REQ_MAKE_EMPTY, '0);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_DELETE,     '1);
        send_req(REQ_INSERT,     '0);
        send_req(REQ_INSERT,     '1);
        send_req(REQ_INSERT,     32'ha5a5_a5a5);
        send_req(REQ_RETRIEVE,   '1);
        send_req(REQ_RETRIEVE,   32'h1234_5678);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_RESET_WALK, '0);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_INSERT,     32'h5a5a_5a5a);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_DELETE,     32'h1234_5678);
        send_req(REQ_DELETE,     '1);
        send_req(REQ_GET_NEXT,   '0);
        send_req(REQ_SPARE_LO,   '1);
        send_req(REQ_SPARE_HI,   '0);
        send_req(REQ_MAKE_EMPTY, '1);
        send_req(REQ_RETRIEVE,   '0);

        // random phases over a small pool of items so deletes and searches hit
        for (int n = 0; n < ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                mode     = $urandom_range(MODE_FILL, MODE_MIXED);
                req_rush = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < 8; k++)
                    pool[k] = $urandom();
            end
            roll = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:
                    op = (roll < 70) ? REQ_INSERT   :
                         (roll < 80) ? REQ_DELETE   :
                         (roll < 90) ? REQ_RETRIEVE : REQ_GET_NEXT;
                MODE_DRAIN:
                    op = (roll < 20) ? REQ_INSERT   :
                         (roll < 65) ? REQ_DELETE   :
                         (roll < 85) ? REQ_RETRIEVE :
                         (roll < 95) ? REQ_GET_NEXT : REQ_MAKE_EMPTY;
                MODE_WALK:
                    op = (roll < 15) ? REQ_INSERT     :
                         (roll < 25) ? REQ_DELETE     :
                         (roll < 60) ? REQ_GET_NEXT   :
                         (roll < 75) ? REQ_RESET_WALK : REQ_RETRIEVE;
                default:
                    op = REQ_W'($urandom_range(0, 7));
            endcase
            if ($urandom_range(0, 99) < 85)
                item = pool[$urandom_range(0, 7)];
            else
                item = $urandom();
            send_req(op, item);
        end
        in_valid <= 1'b0;

        // drain outstanding results, then allow for stragglers
        do
            @(posedge clk);
        while (pending != 0);
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
